### src/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
`default_nettype none
package pli_pkg;

   localparam int MAX_POINTS = 256;
   localparam int IDX_W = 8;
   localparam int CNT_W = 9;
   localparam int DIV_STEPS = 64;
   localparam int MUL_STEPS = 32;
   localparam int STEP_W = 6;
   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_VALUE = 2'd1;
   localparam logic [1:0] ACT_SLOPE = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_EMPTY      = 2'd1;
   localparam logic [1:0] STAT_ZERO_WIDTH = 2'd2;
   localparam logic [1:0] STAT_SAT        = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_WRITE, OP_READ_FIRST, OP_FIRST_CELL, OP_READ_LAST,
      OP_LAST_CELL, OP_SEARCH_INIT, OP_READ_MID, OP_NARROW, OP_LO_CELL, OP_READ_A,
      OP_READ_B, OP_DIFF, OP_DIV_SLOPE_LOAD, OP_DIV_FRAC_LOAD, OP_FRAC_SET,
      OP_DIV_STEP, OP_FRAC_FROM_DIV, OP_MUL_STEP, OP_RESULT
   } pli_op_type;

   typedef enum logic [2:0] {
      RES_ZERO, RES_EMPTY, RES_SINGLE, RES_ZERO_WIDTH, RES_SLOPE, RES_VALUE
   } pli_res_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_CHK_FIRST, S_CHK_LAST, S_BIN_RD, S_BIN_CHK, S_RD_A,
      S_RD_B, S_DIFF, S_PREP, S_DIV, S_FRAC, S_MUL, S_FINISH
   } pli_state_type;

   typedef struct packed {
      pli_op_type  op;
      pli_res_type res_sel;
   } pli_cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_nop;
      logic is_slope;
      logic n_zero;
      logic n_one;
      logic n_le2;
      logic t_less;
      logic span_done;
      logic zero_width;
      logic frac_trivial;
   } pli_status_type;

endpackage
`default_nettype wire

### src/pli_req_if.sv
// Request channel interface carrying one input transaction.
`default_nettype none
interface pli_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [7:0]         entry_index;
   logic signed [31:0] entry_time;
   logic signed [31:0] entry_value;
   logic signed [31:0] query_time;

   modport source (output valid, action, entry_index, entry_time, entry_value, query_time,
                   input ready);
   modport sink (input valid, action, entry_index, entry_time, entry_value, query_time,
                 output ready);
endinterface
`default_nettype wire

### src/pli_rsp_if.sv
// Response channel interface carrying one result transaction.
`default_nettype none
interface pli_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;

   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

### src/pli_ctrl.sv
// Controller state machine sequencing search, division and multiplication.
`default_nettype none
module pli_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire pli_pkg::pli_status_type status,
   output pli_pkg::pli_cmd_type         cmd
);

   pli_pkg::pli_state_type state_ff, state_in;
   pli_pkg::pli_res_type   res_sel_ff, res_sel_in;
   logic [pli_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pli_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::S_IDLE;
         res_sel_ff   <= pli_pkg::RES_ZERO;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_sel_ff   <= res_sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      res_sel_in   = res_sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = pli_pkg::OP_NONE;
      cmd.res_sel  = res_sel_ff;
      unique case (state_ff)
         pli_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pli_pkg::OP_CAPTURE;
               state_in = pli_pkg::S_DISPATCH;
            end
         end
         pli_pkg::S_DISPATCH: begin
            priority if (status.is_load) begin
               cmd.op     = pli_pkg::OP_WRITE;
               res_sel_in = pli_pkg::RES_ZERO;
               state_in   = pli_pkg::S_FINISH;
            end else if (status.is_nop) begin
               res_sel_in = pli_pkg::RES_ZERO;
               state_in   = pli_pkg::S_FINISH;
            end else if (status.n_zero) begin
               res_sel_in = pli_pkg::RES_EMPTY;
               state_in   = pli_pkg::S_FINISH;
            end else if (status.n_le2) begin
               cmd.op   = pli_pkg::OP_FIRST_CELL;
               state_in = pli_pkg::S_RD_A;
            end else begin
               cmd.op   = pli_pkg::OP_READ_FIRST;
               state_in = pli_pkg::S_CHK_FIRST;
            end
         end
         pli_pkg::S_CHK_FIRST: begin
            if (status.t_less) begin
               cmd.op   = pli_pkg::OP_FIRST_CELL;
               state_in = pli_pkg::S_RD_A;
            end else begin
               cmd.op   = pli_pkg::OP_READ_LAST;
               state_in = pli_pkg::S_CHK_LAST;
            end
         end
         pli_pkg::S_CHK_LAST: begin
            if (!status.t_less) begin
               cmd.op   = pli_pkg::OP_LAST_CELL;
               state_in = pli_pkg::S_RD_A;
            end else begin
               cmd.op   = pli_pkg::OP_SEARCH_INIT;
               state_in = pli_pkg::S_BIN_RD;
            end
         end
         pli_pkg::S_BIN_RD: begin
            if (status.span_done) begin
               cmd.op   = pli_pkg::OP_LO_CELL;
               state_in = pli_pkg::S_RD_A;
            end else begin
               cmd.op   = pli_pkg::OP_READ_MID;
               state_in = pli_pkg::S_BIN_CHK;
            end
         end
         pli_pkg::S_BIN_CHK: begin
            cmd.op   = pli_pkg::OP_NARROW;
            state_in = pli_pkg::S_BIN_RD;
         end
         pli_pkg::S_RD_A: begin
            cmd.op   = pli_pkg::OP_READ_A;
            state_in = pli_pkg::S_RD_B;
         end
         pli_pkg::S_RD_B: begin
            cmd.op   = pli_pkg::OP_READ_B;
            state_in = pli_pkg::S_DIFF;
         end
         pli_pkg::S_DIFF: begin
            cmd.op   = pli_pkg::OP_DIFF;
            state_in = pli_pkg::S_PREP;
         end
         pli_pkg::S_PREP: begin
            cnt_in = '0;
            priority if (status.n_one) begin
               res_sel_in = pli_pkg::RES_SINGLE;
               state_in   = pli_pkg::S_FINISH;
            end else if (status.zero_width) begin
               res_sel_in = pli_pkg::RES_ZERO_WIDTH;
               state_in   = pli_pkg::S_FINISH;
            end else if (status.is_slope) begin
               cmd.op   = pli_pkg::OP_DIV_SLOPE_LOAD;
               state_in = pli_pkg::S_DIV;
            end else if (status.frac_trivial) begin
               cmd.op   = pli_pkg::OP_FRAC_SET;
               state_in = pli_pkg::S_MUL;
            end else begin
               cmd.op   = pli_pkg::OP_DIV_FRAC_LOAD;
               state_in = pli_pkg::S_DIV;
            end
         end
         pli_pkg::S_DIV: begin
            cmd.op = pli_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1)) begin
               if (status.is_slope) begin
                  res_sel_in = pli_pkg::RES_SLOPE;
                  state_in   = pli_pkg::S_FINISH;
               end else begin
                  state_in = pli_pkg::S_FRAC;
               end
            end
         end
         pli_pkg::S_FRAC: begin
            cmd.op   = pli_pkg::OP_FRAC_FROM_DIV;
            cnt_in   = '0;
            state_in = pli_pkg::S_MUL;
         end
         pli_pkg::S_MUL: begin
            cmd.op = pli_pkg::OP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1)) begin
               res_sel_in = pli_pkg::RES_VALUE;
               state_in   = pli_pkg::S_FINISH;
            end
         end
         pli_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.op       = pli_pkg::OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = pli_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::S_IDLE;
         end
      endcase
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == pli_pkg::S_DISPATCH)
      else $error("accepted transaction did not reach dispatch");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pli_pkg::S_FINISH)
      else $error("response raised outside finish");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == pli_pkg::S_MUL |-> !cnt_ff[pli_pkg::STEP_W-1])
      else $error("multiply step count overran");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pli_pkg::OP_RESULT) |-> out_free)
      else $error("result written over a pending response");

endmodule
`default_nettype wire

### src/pli_datapath.sv
// Datapath: grid memories, search registers, serial divider and multiplier.
`default_nettype none
module pli_datapath (
   input  wire logic                    clock,
   input  wire pli_pkg::pli_cmd_type    cmd,
   output pli_pkg::pli_status_type      status,
   input  wire logic [pli_pkg::CNT_W-1:0] points,
   input  wire logic [1:0]              req_action,
   input  wire logic [7:0]              req_entry_index,
   input  wire logic signed [31:0]      req_entry_time,
   input  wire logic signed [31:0]      req_entry_value,
   input  wire logic signed [31:0]      req_query_time,
   output logic signed [31:0]           rsp_result_value,
   output logic [1:0]                   rsp_status
);

   logic signed [31:0] mem_time [pli_pkg::MAX_POINTS];
   logic signed [31:0] mem_value [pli_pkg::MAX_POINTS];

   logic [1:0]                act_ff;
   logic [pli_pkg::IDX_W-1:0] idx_ff;
   logic signed [31:0]        etime_ff, evalue_ff, tq_ff;
   logic signed [31:0]        rd_time_ff, rd_value_ff;
   logic [pli_pkg::IDX_W-1:0] lo_ff, hi_ff, cell_ff, rd_addr;
   logic signed [31:0]        a_ff, va_ff;
   logic signed [32:0]        d_ff, w_ff, dv_ff;
   logic [63:0]               num_ff, quo_ff;
   logic [32:0]               den_ff, rem_ff;
   logic [31:0]               f_ff;
   logic [64:0]               acc_ff;
   logic signed [31:0]        res_ff;
   logic [1:0]                st_ff;

   logic [pli_pkg::IDX_W-1:0] mid, n_m1, n_m2;
   logic [pli_pkg::IDX_W:0]   lo_hi_sum;
   logic [32:0]               md, mw, mdv;
   logic [33:0]               rem_sh;
   logic                      rem_ge;
   logic [64:0]               acc_rnd;
   logic [32:0]               step_mag;
   logic [33:0]               value_sum;
   logic                      slope_neg;
   logic [31:0]               slope_res;
   logic                      slope_sat;

   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid  = lo_hi_sum[pli_pkg::IDX_W:1];
   assign n_m1 = pli_pkg::IDX_W'(points - 1'b1);
   assign n_m2 = pli_pkg::IDX_W'(points - 2'd2);

   assign md  = d_ff[32]  ? 33'(-d_ff)  : 33'(d_ff);
   assign mw  = w_ff[32]  ? 33'(-w_ff)  : 33'(w_ff);
   assign mdv = dv_ff[32] ? 33'(-dv_ff) : 33'(dv_ff);

   always_comb begin
      unique case (cmd.op)
         pli_pkg::OP_READ_FIRST: rd_addr = pli_pkg::IDX_W'(1);
         pli_pkg::OP_READ_LAST:  rd_addr = n_m2;
         pli_pkg::OP_READ_MID:   rd_addr = mid;
         pli_pkg::OP_READ_B:     rd_addr = cell_ff + 1'b1;
         default:                rd_addr = cell_ff;
      endcase
   end

   assign status.is_load      = (act_ff == pli_pkg::ACT_LOAD);
   assign status.is_nop       = (act_ff == pli_pkg::ACT_NOP);
   assign status.is_slope     = (act_ff == pli_pkg::ACT_SLOPE);
   assign status.n_zero       = (points == '0);
   assign status.n_one        = (points == pli_pkg::CNT_W'(1));
   assign status.n_le2        = (points <= pli_pkg::CNT_W'(2));
   assign status.t_less       = (tq_ff < rd_time_ff);
   assign status.span_done    = ((hi_ff - lo_ff) <= pli_pkg::IDX_W'(1));
   assign status.zero_width   = (w_ff == '0);
   assign status.frac_trivial = (d_ff == '0) || (d_ff[32] != w_ff[32]) || (md >= mw);

   // One restoring division step per cycle.
   assign rem_sh = {rem_ff, num_ff[63]};
   assign rem_ge = (rem_sh >= {1'b0, den_ff});

   // Round to nearest with ties away from zero, applied to the magnitude.
   assign acc_rnd   = acc_ff + 65'(64'h4000_0000);
   assign step_mag  = acc_rnd[63:31];
   assign value_sum = dv_ff[32] ? (34'(va_ff) - {1'b0, step_mag})
                                : (34'(va_ff) + {1'b0, step_mag});

   assign slope_neg = dv_ff[32] ^ w_ff[32];
   always_comb begin
      if (slope_neg) begin
         slope_sat = (quo_ff[63:32] != '0) || (quo_ff[31] && (quo_ff[30:0] != '0));
         slope_res = slope_sat ? 32'h8000_0000 : (32'd0 - quo_ff[31:0]);
      end else begin
         slope_sat = (quo_ff[63:31] != '0);
         slope_res = slope_sat ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == pli_pkg::OP_WRITE) begin
         mem_time[idx_ff]  <= etime_ff;
         mem_value[idx_ff] <= evalue_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_time_ff  <= mem_time[rd_addr];
      rd_value_ff <= mem_value[rd_addr];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         pli_pkg::OP_CAPTURE: begin
            act_ff    <= req_action;
            idx_ff    <= req_entry_index;
            etime_ff  <= req_entry_time;
            evalue_ff <= req_entry_value;
            tq_ff     <= req_query_time;
         end
         pli_pkg::OP_FIRST_CELL: cell_ff <= '0;
         pli_pkg::OP_LAST_CELL:  cell_ff <= n_m2;
         pli_pkg::OP_LO_CELL:    cell_ff <= lo_ff;
         pli_pkg::OP_SEARCH_INIT: begin
            lo_ff <= '0;
            hi_ff <= n_m1;
         end
         pli_pkg::OP_NARROW: begin
            if (tq_ff < rd_time_ff) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= mid;
            end
         end
         pli_pkg::OP_READ_B: begin
            a_ff  <= rd_time_ff;
            va_ff <= rd_value_ff;
         end
         pli_pkg::OP_DIFF: begin
            d_ff  <= 33'(tq_ff) - 33'(a_ff);
            w_ff  <= 33'(rd_time_ff) - 33'(a_ff);
            dv_ff <= 33'(rd_value_ff) - 33'(va_ff);
         end
         pli_pkg::OP_DIV_SLOPE_LOAD: begin
            num_ff <= {15'd0, mdv, 16'd0};
            den_ff <= mw;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         pli_pkg::OP_DIV_FRAC_LOAD: begin
            num_ff <= {md, 31'd0};
            den_ff <= mw;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         pli_pkg::OP_DIV_STEP: begin
            num_ff <= {num_ff[62:0], 1'b0};
            rem_ff <= rem_ge ? 33'(rem_sh - {1'b0, den_ff}) : rem_sh[32:0];
            quo_ff <= {quo_ff[62:0], rem_ge};
         end
         pli_pkg::OP_FRAC_SET: begin
            // Fraction is zero when the query lies behind the cell start, one past its end.
            f_ff   <= ((d_ff == '0) || (d_ff[32] != w_ff[32])) ? 32'd0 : 32'h8000_0000;
            acc_ff <= '0;
         end
         pli_pkg::OP_FRAC_FROM_DIV: begin
            f_ff   <= quo_ff[31:0];
            acc_ff <= '0;
         end
         pli_pkg::OP_MUL_STEP: begin
            acc_ff <= {acc_ff[63:0], 1'b0} + (f_ff[31] ? {32'd0, mdv} : 65'd0);
            f_ff   <= {f_ff[30:0], 1'b0};
         end
         pli_pkg::OP_RESULT: begin
            unique case (cmd.res_sel)
               pli_pkg::RES_EMPTY: begin
                  res_ff <= '0;
                  st_ff  <= pli_pkg::STAT_EMPTY;
               end
               pli_pkg::RES_SINGLE: begin
                  res_ff <= status.is_slope ? 32'sd0 : va_ff;
                  st_ff  <= pli_pkg::STAT_OK;
               end
               pli_pkg::RES_ZERO_WIDTH: begin
                  res_ff <= status.is_slope ? 32'sd0 : va_ff;
                  st_ff  <= pli_pkg::STAT_ZERO_WIDTH;
               end
               pli_pkg::RES_SLOPE: begin
                  res_ff <= slope_res;
                  st_ff  <= slope_sat ? pli_pkg::STAT_SAT : pli_pkg::STAT_OK;
               end
               pli_pkg::RES_VALUE: begin
                  res_ff <= value_sum[31:0];
                  st_ff  <= pli_pkg::STAT_OK;
               end
               default: begin
                  res_ff <= '0;
                  st_ff  <= pli_pkg::STAT_OK;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;

endmodule
`default_nettype wire

### src/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator with its register port.
// Each request transaction yields exactly one response transaction. A load
// writes one table entry and answers 0 from the finish state. A query with
// more than two points checks the first and last cells and otherwise runs a
// binary search over the grid memory (one registered read per search step).
// A slope query then runs a bit-serial divider; a value query runs it (unless
// the fraction is 0 or 1) and a shift-add multiplier. One transaction is processed
// at a time; a new request is taken while the previous response still waits
// in the output register. The table holds 256 points; point_count above 256
// is treated as 256. Write point_count only while the block is idle.
`default_nettype none
module piecewise_linear_interpolator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pli_req_if.sink                            req_if,
   pli_rsp_if.source                          rsp_if,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pli_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic [pli_pkg::CNT_W-1:0] point_count_ff;
   logic [pli_pkg::CNT_W-1:0] points;
   logic                      csr_write;
   pli_pkg::pli_cmd_type      cmd;
   pli_pkg::pli_status_type   status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {23'd0, point_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_write) begin
         point_count_ff <= csr_pwdata[pli_pkg::CNT_W-1:0];
      end
   end

   assign points = (point_count_ff > pli_pkg::CNT_W'(pli_pkg::MAX_POINTS))
                   ? pli_pkg::CNT_W'(pli_pkg::MAX_POINTS) : point_count_ff;

   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pli_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .points           (points),
      .req_action       (req_if.action),
      .req_entry_index  (req_if.entry_index),
      .req_entry_time   (req_if.entry_time),
      .req_entry_value  (req_if.entry_value),
      .req_query_time   (req_if.query_time),
      .rsp_result_value (rsp_if.result_value),
      .rsp_status       (rsp_if.status)
   );

endmodule
`default_nettype wire
